/* rtl/sm3_hash_engine_top_macros.svh */
// Assertion macros for the SM3 hash engine.
`ifndef SM3_HASH_ENGINE_TOP_MACROS_SVH
`define SM3_HASH_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SM3_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define SM3_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define SM3_ASSERT(lbl, clk, rstn, prop, msg)
`define SM3_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* rtl/sm3_pkg.sv */
// ----------------------------------------------------------------------------
// sm3_pkg
// Shared types, constants and round functions of the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

  localparam logic [31:0] TLow  = 32'h79CC4519;
  localparam logic [31:0] THigh = 32'h7A879D8A;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [5:0]  LenPos = 6'd56;
  localparam int unsigned NumRounds = 64;

  localparam logic [31:0] IvReset [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       start_msg;  // load chaining value from IV
    logic       put_byte;   // write put_val into buffer at fill position
    logic [7:0] put_val;
    logic       round;      // run one compression round
    logic       load_exp;   // load block into window and working regs
    logic       fold;       // xor working regs into chaining value
    logic       clr_total;  // clear byte total and fill count
    logic       cnt_byte;   // bump byte total
  } sm3_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [5:0]  fill;
    logic [63:0] bits;
  } sm3_stat_t;

  function automatic logic [31:0] rol(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rol(x, 5'd9) ^ rol(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rol(x, 5'd15) ^ rol(x, 5'd23);
  endfunction

endpackage

/* rtl/sm3_hash_engine_top.sv */
// ----------------------------------------------------------------------------
// sm3_hash_engine_top
// SM3 hash engine: streams big-endian words, pads, returns eight digest words.
// ----------------------------------------------------------------------------
// Takes one message word per transfer; its valid bytes, and on the final
// word the padding, go into the block buffer at one byte per cycle, pausing
// while a full block compresses. Each 64-byte block runs 64 compression
// rounds on a single round unit, one per cycle, between a load and a fold
// step; the final word adds one or two more blocks. The eight digest words
// come out in order. The user must write IV registers through the config
// port only while idle (unchecked); they take effect at next message start.
module sm3_hash_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] message_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import sm3_pkg::*;
`include "sm3_hash_engine_top_macros.svh"

  logic [31:0] iv_q [8];
  sm3_cmd_t    cmd;
  sm3_stat_t   stat;
  logic [6:0]  rnd;

  assign cfg_ready_o = 1'b1;

  // IV register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) iv_q[i] <= IvReset[i];
    end else if (cfg_valid_i) begin
      iv_q[cfg_index_i] <= cfg_data_i;
    end
  end

  sm3_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .message_word_i, .valid_bytes_i,
    .end_of_message_i, .out_valid_o, .out_stall_i, .word_index_o, .last_word_o,
    .cmd_o(cmd), .rnd_o(rnd), .stat_i(stat)
  );

  sm3_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .rnd_i(rnd), .iv_i(iv_q), .dsel_i(word_index_o),
    .stat_o(stat), .dword_o(digest_word_o)
  );

  `SM3_ASSERT(a_no_in_while_out, clk_i, rst_ni, !(out_valid_o && !in_stall_o), "input open during digest")
  `SM3_ASSERT(a_round_range, clk_i, rst_ni, !cmd.round || rnd < 7'd64, "round count out of range")
  `SM3_ASSERT_NEXT(a_idx_adv, clk_i, rst_ni, out_valid_o && !out_stall_i && !last_word_o, out_valid_o, "digest cut short")

endmodule

/* rtl/sm3_datapath.sv */
// ----------------------------------------------------------------------------
// sm3_datapath
// Block buffer, byte counters, message expansion window, round logic and
// chaining value of the SM3 engine.
// ----------------------------------------------------------------------------
module sm3_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sm3_pkg::sm3_cmd_t   cmd_i,
  input  logic [6:0]          rnd_i,
  input  logic [31:0]         iv_i [8],
  input  logic [2:0]          dsel_i,
  output sm3_pkg::sm3_stat_t  stat_o,
  output logic [31:0]         dword_o
);
  import sm3_pkg::*;

  logic [31:0] buf_q [16];
  logic [31:0] win_q [16];
  logic [31:0] wr_q [8];
  logic [31:0] wr_d [8];
  logic [31:0] cv_q [8];
  logic [63:0] total_q;
  logic [5:0]  fill_q;

  logic [3:0]  widx;
  logic [1:0]  bsel;
  logic [31:0] wnew, w0, w4, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
  logic        lo;

  assign widx = fill_q[5:2];
  assign bsel = fill_q[1:0];
  assign stat_o.fill = fill_q;
  assign stat_o.bits = {total_q[60:0], 3'b000};
  assign dword_o = cv_q[dsel_i];

  // expansion and round
  always_comb begin
    lo   = (rnd_i < 7'd16);
    w0   = win_q[0];
    w4   = win_q[4];
    wnew = p1(win_q[0] ^ win_q[7] ^ rol(win_q[13], 5'd15)) ^ rol(win_q[3], 5'd7)
           ^ win_q[10];
    tj   = lo ? TLow : THigh;
    a12  = rol(wr_q[0], 5'd12);
    ss1  = rol(a12 + wr_q[4] + rol(tj, rnd_i[4:0]), 5'd7);
    ss2  = ss1 ^ a12;
    ff   = lo ? (wr_q[0] ^ wr_q[1] ^ wr_q[2])
              : ((wr_q[0] & wr_q[1]) | (wr_q[0] & wr_q[2]) | (wr_q[1] & wr_q[2]));
    gg   = lo ? (wr_q[4] ^ wr_q[5] ^ wr_q[6])
              : ((wr_q[4] & wr_q[5]) | (~wr_q[4] & wr_q[6]));
    tt1  = ff + wr_q[3] + ss2 + (w0 ^ w4);
    tt2  = gg + wr_q[7] + ss1 + w0;
    wr_d[0] = tt1;
    wr_d[1] = wr_q[0];
    wr_d[2] = rol(wr_q[1], 5'd9);
    wr_d[3] = wr_q[2];
    wr_d[4] = p0(tt2);
    wr_d[5] = wr_q[4];
    wr_d[6] = rol(wr_q[5], 5'd19);
    wr_d[7] = wr_q[6];
  end

  // counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      fill_q  <= '0;
    end else if (cmd_i.clr_total) begin
      total_q <= '0;
      fill_q  <= '0;
    end else begin
      if (cmd_i.cnt_byte) total_q <= total_q + 64'd1;
      if (cmd_i.put_byte) fill_q <= fill_q + 6'd1;
    end
  end

  // chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) cv_q[i] <= IvReset[i];
    end else if (cmd_i.start_msg) begin
      for (int i = 0; i < 8; i++) cv_q[i] <= iv_i[i];
    end else if (cmd_i.fold) begin
      for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] ^ wr_q[i];
    end
  end

  // buffer, window and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.put_byte) begin
      case (bsel)
        2'd0: buf_q[widx][31:24] <= cmd_i.put_val;
        2'd1: buf_q[widx][23:16] <= cmd_i.put_val;
        2'd2: buf_q[widx][15:8]  <= cmd_i.put_val;
        default: buf_q[widx][7:0] <= cmd_i.put_val;
      endcase
    end
    if (cmd_i.load_exp) begin
      for (int i = 0; i < 16; i++) win_q[i] <= buf_q[i];
      for (int i = 0; i < 8; i++) wr_q[i] <= cv_q[i];
    end else if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
      win_q[15] <= wnew;
      for (int i = 0; i < 8; i++) wr_q[i] <= wr_d[i];
    end
  end

endmodule

/* rtl/sm3_ctrl.sv */
// ----------------------------------------------------------------------------
// sm3_ctrl
// Sequencer: feeds bytes and padding, runs 64 rounds per block, emits digest.
// ----------------------------------------------------------------------------
module sm3_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        message_word_i,
  input  logic [2:0]         valid_bytes_i,
  input  logic               end_of_message_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         word_index_o,
  output logic               last_word_o,
  output sm3_pkg::sm3_cmd_t  cmd_o,
  output logic [6:0]         rnd_o,
  input  sm3_pkg::sm3_stat_t stat_i
);
  import sm3_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BYTES, ST_LOAD, ST_ROUND, ST_FOLD, ST_PAD, ST_OUT
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] word_q, word_d;
  logic [2:0]  left_q, left_d;
  logic        last_q, last_d;
  logic        open_q, open_d;
  logic        padding_q, padding_d;  // message ended, padding in progress
  logic        pad80_q, pad80_d;      // pad byte already placed
  logic        lenok_q, lenok_d;      // current block carries the length field
  logic [63:0] bits_q, bits_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [2:0]  oidx_q, oidx_d;
  logic [2:0]  nv;
  logic [7:0]  pb;
  logic [2:0]  lb;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = (state_q == ST_OUT);
  assign word_index_o = oidx_q;
  assign last_word_o  = (oidx_q == 3'd7);
  assign rnd_o        = rnd_q;
  assign nv = (valid_bytes_i > 3'd4) ? 3'd4 : valid_bytes_i;
  assign lb = 3'd7 - stat_i.fill[2:0];

  always_comb begin
    state_d = state_q; word_d = word_q; left_d = left_q; last_d = last_q;
    open_d = open_q; padding_d = padding_q; pad80_d = pad80_q; bits_d = bits_q;
    rnd_d = rnd_q; oidx_d = oidx_q; lenok_d = lenok_q;
    cmd_o = '0;
    pb = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (!open_q) begin
            cmd_o.start_msg = 1'b1;
            cmd_o.clr_total = 1'b1;
            open_d = 1'b1;
          end
          word_d = message_word_i;
          left_d = nv;
          last_d = end_of_message_i;
          state_d = ST_BYTES;
        end
      end
      ST_BYTES: begin
        if (left_q != 3'd0) begin
          cmd_o.put_byte = 1'b1;
          cmd_o.put_val  = word_q[31:24];
          cmd_o.cnt_byte = 1'b1;
          word_d = {word_q[23:0], 8'h00};
          left_d = left_q - 3'd1;
          if (stat_i.fill == 6'd63) state_d = ST_LOAD;
        end else if (last_q) begin
          padding_d = 1'b1;
          pad80_d = 1'b0;
          bits_d = stat_i.bits;
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (!pad80_q) begin
          pb = PadByte;
          // the length fits this block only when the pad byte lands ahead of it
          lenok_d = (stat_i.fill < LenPos);
        end else if (lenok_q && stat_i.fill >= LenPos) begin
          case (lb)
            3'd7: pb = bits_q[63:56];
            3'd6: pb = bits_q[55:48];
            3'd5: pb = bits_q[47:40];
            3'd4: pb = bits_q[39:32];
            3'd3: pb = bits_q[31:24];
            3'd2: pb = bits_q[23:16];
            3'd1: pb = bits_q[15:8];
            default: pb = bits_q[7:0];
          endcase
        end
        cmd_o.put_byte = 1'b1;
        cmd_o.put_val  = pb;
        pad80_d = 1'b1;
        if (stat_i.fill == 6'd63) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load_exp = 1'b1;
        rnd_d = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == 7'(NumRounds - 1)) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        if (padding_q) begin
          // finish once the block with the length is folded, else pad one more
          if (lenok_q) begin
            oidx_d = '0;
            state_d = ST_OUT;
          end else begin
            lenok_d = 1'b1;
            state_d = ST_PAD;
          end
        end else state_d = ST_BYTES;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            state_d = ST_IDLE;
            open_d = 1'b0;
            padding_d = 1'b0;
            cmd_o.clr_total = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      open_q <= 1'b0;
      padding_q <= 1'b0;
      pad80_q <= 1'b0;
      lenok_q <= 1'b0;
      left_q <= '0;
      last_q <= 1'b0;
      rnd_q <= '0;
      oidx_q <= '0;
      word_q <= '0;
      bits_q <= '0;
    end else begin
      state_q <= state_d;
      open_q <= open_d;
      padding_q <= padding_d;
      pad80_q <= pad80_d;
      lenok_q <= lenok_d;
      left_q <= left_d;
      last_q <= last_d;
      rnd_q <= rnd_d;
      oidx_q <= oidx_d;
      word_q <= word_d;
      bits_q <= bits_d;
    end
  end

endmodule

/* dv/tb_sm3_hash_engine_top.sv */
// ----------------------------------------------------------------------------
// tb_sm3_hash_engine_top
// Self-checking bench: streams messages into the SM3 engine and checks digests.
// ----------------------------------------------------------------------------
// A directed table covers the standard "abc" vector, the empty message and
// short and oversize byte counts; IV extremes and random messages follow,
// with IV rewrites between phases. Every digest word is predicted by a
// local SM3 model and compared field by field against the engine output.
module tb_sm3_hash_engine_top;
  import sm3_pkg::*;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        eom;
    logic        has_ref;   // a typed-in digest word 0 to check against
    logic [31:0] ref_d0;
  } stim_row_t;

  typedef struct {
    logic [31:0] digest;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  localparam int RowCount = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] message_word_i = '0;
  logic [2:0]  valid_bytes_i = '0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  sm3_hash_engine_top uut (.*);

  always #5 clk_i = ~clk_i;

  // Hash model state
  logic [31:0] iv_shadow [8];
  logic [31:0] chain [8];
  logic [31:0] blk [16];
  logic [63:0] msg_bytes;
  logic [5:0]  fill_pos;
  logic        msg_busy;

  digest_beat_t digest_q[$];
  logic [31:0]  ref_first_q[$];
  logic         ref_has_q[$];
  int           mismatches = 0;
  bit           stim_done = 1'b0;
  int           beats_seen = 0;

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    n = n % 32;
    return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
  endfunction

  function automatic logic [31:0] mix0(logic [31:0] x);
    return x ^ rotl(x, 9) ^ rotl(x, 17);
  endfunction

  function automatic logic [31:0] mix1(logic [31:0] x);
    return x ^ rotl(x, 15) ^ rotl(x, 23);
  endfunction

  task automatic compress_blk();
    logic [31:0] w [68];
    logic [31:0] a, b, c, d, e, f, g, h, a12, ss1, ss2, ff, gg, tt1, tt2, tj;
    for (int j = 0; j < 16; j++) w[j] = blk[j];
    for (int j = 16; j < 68; j++)
      w[j] = mix1(w[j-16] ^ w[j-9] ^ rotl(w[j-3], 15)) ^ rotl(w[j-13], 7) ^ w[j-6];
    {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                chain[4], chain[5], chain[6], chain[7]};
    for (int j = 0; j < 64; j++) begin
      tj  = (j < 16) ? TLow : THigh;
      a12 = rotl(a, 12);
      ss1 = rotl(a12 + e + rotl(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c; c = rotl(b, 9); b = a; a = tt1;
      h = g; g = rotl(f, 19); f = e; e = mix0(tt2);
    end
    chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
    chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
  endtask

  task automatic append_byte(logic [7:0] v);
    int sh;
    sh = 24 - 8 * fill_pos[1:0];
    blk[fill_pos[5:2]] = (blk[fill_pos[5:2]] & ~(32'hFF << sh)) | (32'(v) << sh);
    fill_pos = fill_pos + 6'd1;
    if (fill_pos == 6'd0) compress_blk();
  endtask

  // Advance the model by one accepted word, queueing digest words on the last
  task automatic predict_word(logic [31:0] word, logic [2:0] nb, logic eom);
    int n;
    logic [63:0] bits;
    if (!msg_busy) begin
      chain = iv_shadow;
      msg_bytes = '0;
      fill_pos = '0;
      msg_busy = 1'b1;
    end
    n = (nb > 3'd4) ? 4 : nb;
    for (int i = 0; i < n; i++) begin
      append_byte(word[31 - 8*i -: 8]);
      msg_bytes++;
    end
    if (eom) begin
      bits = msg_bytes << 3;
      append_byte(PadByte);
      while (fill_pos != LenPos) append_byte(8'h00);
      for (int i = 0; i < 8; i++) append_byte(bits[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++)
        digest_q.push_back('{chain[i], 3'(i), i == 7});
      msg_busy = 1'b0;
    end
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
  endfunction

  // Send one word, hold until transfer
  task automatic send_word(logic [31:0] word, logic [2:0] nb, logic eom);
    repeat (gap_len()) @(posedge clk_i);
    in_valid_i <= 1'b1;
    message_word_i <= word;
    valid_bytes_i <= nb;
    end_of_message_i <= eom;
    do @(posedge clk_i); while (in_stall_o);
    predict_word(word, nb, eom);
    in_valid_i <= 1'b0;
    // the engine stalls the input after every transfer
    @(posedge clk_i);
  endtask

  task automatic wait_drain();
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_iv(logic [2:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    iv_shadow[idx] = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_message(int words);
    for (int i = 0; i < words - 1; i++)
      send_word($urandom, ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4,
                1'b0);
    send_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
  endtask

  // Receiver stall pattern
  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else if ($urandom_range(0, 3) == 0) out_stall_i <= ($urandom_range(0, 9) != 0);
  end

  // Check each digest word transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_seen++;
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest word %h", digest_word_o);
      end else begin
        digest_beat_t exp_b;
        logic         has_ref;
        logic [31:0]  ref_d0;
        exp_b = digest_q.pop_front();
        if (exp_b.idx == 3'd0 && ref_has_q.size() != 0) begin
          has_ref = ref_has_q.pop_front();
          ref_d0 = ref_first_q.pop_front();
          if (has_ref && ref_d0 !== digest_word_o) begin
            mismatches++;
            if (mismatches <= 10) $display("known vector mismatch: exp %h got %h",
                                           ref_d0, digest_word_o);
          end
        end
        if (exp_b.digest !== digest_word_o || exp_b.idx !== word_index_o ||
            exp_b.last !== last_word_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b", exp_b.digest,
                     exp_b.idx, exp_b.last, digest_word_o, word_index_o, last_word_o);
        end
      end
    end
  end

  stim_row_t rows [RowCount] = '{
    '{32'h61626300, 3'd3, 1'b1, 1'b1, 32'h66C7F0F4},  // "abc" standard vector
    '{32'h00000000, 3'd0, 1'b1, 1'b1, 32'h1AB21D83},  // empty message
    '{32'hFFFFFFFF, 3'd4, 1'b0, 1'b0, 32'h0},
    '{32'h12345678, 3'd1, 1'b0, 1'b0, 32'h0},         // short word, not final
    '{32'hABCDEF01, 3'd7, 1'b0, 1'b0, 32'h0},         // count above four
    '{32'h00000000, 3'd5, 1'b0, 1'b0, 32'h0},
    '{32'hDEADBEEF, 3'd2, 1'b0, 1'b0, 32'h0},
    '{32'hFFFFFFFF, 3'd6, 1'b1, 1'b0, 32'h0},
    '{32'h80000000, 3'd4, 1'b1, 1'b0, 32'h0},
    '{32'h5A5A5A5A, 3'd0, 1'b1, 1'b0, 32'h0}
  };

  initial begin
    iv_shadow = IvReset;
    msg_busy = 1'b0;
    msg_bytes = '0;
    fill_pos = '0;
    blk = '{default: '0};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int r = 0; r < RowCount; r++) begin
      if (rows[r].eom) begin
        ref_has_q.push_back(rows[r].has_ref);
        ref_first_q.push_back(rows[r].ref_d0);
      end
      send_word(rows[r].word, rows[r].nbytes, rows[r].eom);
    end
    // 64-byte message: padding spills into a second block
    for (int i = 0; i < 16; i++) send_word($urandom, 3'd4, i == 15);
    wait_drain();

    // IV extremes
    for (int k = 0; k < 8; k++) write_iv(3'(k), 32'h0);
    send_word(32'h0, 3'd4, 1'b1);
    wait_drain();
    for (int k = 0; k < 8; k++) write_iv(3'(k), 32'hFFFFFFFF);
    send_word(32'hFFFFFFFF, 3'd4, 1'b1);
    wait_drain();

    // Random phases, IV rewrites between
    for (int ph = 0; ph < 5; ph++) begin
      for (int k = 0; k < 8; k++)
        write_iv(3'(k), (ph == 4) ? IvReset[k] : $urandom);
      for (int m = 0; m < 12; m++) begin
        random_message(($urandom_range(0, 7) == 0) ? $urandom_range(14, 34)
                                                  : $urandom_range(1, 6));
        if (m == 5) wait_drain();  // hold the sender until all digests are back
      end
      wait_drain();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    @(posedge clk_i);
    if (mismatches == 0 && digest_q.size() == 0)
      $display("PASS sm3_hash_engine_top");
    else
      $display("FAIL sm3_hash_engine_top");
    $finish;
  end

  initial begin
    #20000000;
    $display("FAIL sm3_hash_engine_top");
    $finish;
  end

endmodule
